// File: hdl/tpc_pkg.sv
// Shared constants, codes and types of the touch press capture controller.
`default_nettype none

package tpc_pkg;

    // Fixed field widths.
    localparam int unsigned SAMPLE_BITS  = 10;
    localparam int unsigned CFG_BITS     = 10;
    localparam int unsigned TIMEOUT_BITS = 16;
    localparam int unsigned HOLD_BITS    = 16;
    localparam int unsigned POS_X_BITS   = 9;
    localparam int unsigned POS_Y_BITS   = 8;
    localparam int unsigned REG_IDX_BITS = 3;

    // Default screen geometry in pixels.
    localparam int unsigned DEF_SCREEN_WIDTH  = 320;
    localparam int unsigned DEF_SCREEN_HEIGHT = 240;

    // Configuration register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_X_RAW_MIN         = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_X_RAW_MAX         = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_Y_RAW_MIN         = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_Y_RAW_MAX         = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_PRESS_SETTLE_MS   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_SETTLE_MS = 3'd5;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] RST_RAW_MIN   = 10'd0;
    localparam logic [CFG_BITS-1:0] RST_RAW_MAX   = 10'd1023;
    localparam logic [CFG_BITS-1:0] RST_SETTLE_MS = 10'd100;

    // Input word opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    // Result status codes.
    localparam logic STATUS_CAPTURED = 1'b0;
    localparam logic STATUS_TIMEOUT  = 1'b1;

    // Start request for one axis mapper.
    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] raw_min;
        logic [SAMPLE_BITS-1:0] raw_max;
    } tpc_map_req_t;

endpackage

`default_nettype wire

// File: hdl/tpc_axis_map.sv
// Axis mapper: clamp a raw sample to its window and scale it to pixels by bit-serial division.
`default_nettype none

module tpc_axis_map import tpc_pkg::*; #(
    parameter int unsigned SIZE   = DEF_SCREEN_WIDTH,
    parameter bit          INVERT = 1'b0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tpc_map_req_t              req,
    output logic                      busy,
    output logic [$clog2(SIZE)-1:0]   pos
);

    localparam int unsigned PW = $clog2(SIZE);
    localparam int unsigned QW = $clog2(SIZE + 1);
    localparam int unsigned NW = SAMPLE_BITS + QW;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0]          num_reg, num_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] span_reg, span_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic [PW-1:0]          pos_reg, pos_next;

    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS:0]   trial;
    logic                   fits;
    logic [QW-1:0]          quot;
    logic [QW-1:0]          mapped;
    logic [QW-1:0]          limited;

    assign diff    = req.sample - req.raw_min;
    assign trial   = {rem_reg, num_reg[NW-1]};
    assign fits    = trial >= {1'b0, span_reg};
    assign quot    = num_reg[QW-1:0];
    assign mapped  = INVERT ? (QW'(SIZE) - quot) : quot;
    assign limited = (mapped >= QW'(SIZE)) ? QW'(SIZE - 1) : mapped;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        span_next = span_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (req.start) begin
            if (req.sample < req.raw_min) begin
                pos_next = '0;
            end else if (req.sample > req.raw_max) begin
                pos_next = PW'(SIZE - 1);
            end else if (req.raw_max == req.raw_min) begin
                pos_next = '0;
            end else begin
                num_next  = NW'(SIZE) * NW'(diff);
                rem_next  = '0;
                span_next = req.raw_max - req.raw_min;
                cnt_next  = CW'(NW);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                // one quotient bit per cycle, shifted in behind the dividend
                if (fits) begin
                    rem_next = SAMPLE_BITS'(trial - {1'b0, span_reg});
                end else begin
                    rem_next = SAMPLE_BITS'(trial);
                end
                num_next = {num_reg[NW-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
            end else begin
                pos_next  = PW'(limited);
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        span_reg <= span_next;
    end

    assign busy = busy_reg;
    assign pos  = pos_reg;

endmodule

`default_nettype wire

// File: hdl/touch_press_capture_controller_top.sv
// Touch press capture controller: capture sequencer, calibration registers and result register.
`default_nettype none

// Usage
//   s_* channel: one word per millisecond tick (s_op = tick) carrying the pen level and the
//   X/Y ADC readings, or an arm request (s_op = arm) carrying the timeout in ms (0 = none).
//   An arm drops any capture in progress and starts a new one.
//   m_* channel: at most one word per tick, either a captured position with hold time or a
//   timeout status with zero position and hold time.
//   cfg_* channel: writes calibration window and settle times; always ready, and indexes
//   beyond the register list are dropped. Write only while no capture is in flight.
// Timing
//   A result is loaded into the output register in the cycle after the tick that causes it.
//   The tick that samples X/Y starts both axis mappers, whose bit-serial dividers keep
//   s_ready low until both finish; other words do not hold off the next one.
// Reset and stall
//   aresetn (synchronous, active low) returns the sequencer to idle, clears the counters and
//   restores the calibration defaults. While a result waits on a low m_ready, s_ready is held
//   low so that no later result can overwrite it; it rises in the cycle the result is taken.

module touch_press_capture_controller_top import tpc_pkg::*; #(
    parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic                    s_pen_down,
    input  logic [SAMPLE_BITS-1:0]  s_sample_x,
    input  logic [SAMPLE_BITS-1:0]  s_sample_y,
    input  logic [TIMEOUT_BITS-1:0] s_timeout_ms,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_status,
    output logic [POS_X_BITS-1:0]   m_pos_x,
    output logic [POS_Y_BITS-1:0]   m_pos_y,
    output logic [HOLD_BITS-1:0]    m_hold_ms,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int unsigned X_BITS = $clog2(SCREEN_WIDTH);
    localparam int unsigned Y_BITS = $clog2(SCREEN_HEIGHT);

    typedef enum logic [4:0] {
        PH_IDLE           = 5'b00001,
        PH_WAIT_PRESS     = 5'b00010,
        PH_PRESS_SETTLE   = 5'b00100,
        PH_WAIT_RELEASE   = 5'b01000,
        PH_RELEASE_SETTLE = 5'b10000
    } phase_t;

    // calibration and settle registers
    logic [CFG_BITS-1:0] x_raw_min_reg, x_raw_max_reg;
    logic [CFG_BITS-1:0] y_raw_min_reg, y_raw_max_reg;
    logic [CFG_BITS-1:0] press_settle_reg, release_settle_reg;

    // sequencer state
    phase_t                  phase_reg, phase_next;
    logic [CFG_BITS-1:0]     settle_reg, settle_next;
    logic [TIMEOUT_BITS-1:0] timeout_left_reg, timeout_left_next;
    logic                    timeout_en_reg, timeout_en_next;
    logic [HOLD_BITS-1:0]    hold_reg, hold_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic                    m_status_reg, m_status_next;
    logic [POS_X_BITS-1:0]   m_pos_x_reg, m_pos_x_next;
    logic [POS_Y_BITS-1:0]   m_pos_y_reg, m_pos_y_next;
    logic [HOLD_BITS-1:0]    m_hold_reg, m_hold_next;

    logic                    accept;
    logic                    take_sample;
    logic                    emit;
    logic                    emit_timeout;
    logic [HOLD_BITS-1:0]    emit_hold;
    logic [HOLD_BITS-1:0]    hold_bumped;
    logic [CFG_BITS-1:0]     settle_dec;

    tpc_map_req_t            map_req_x, map_req_y;
    logic                    busy_x, busy_y;
    logic [X_BITS-1:0]       held_x;
    logic [Y_BITS-1:0]       held_y;

    // Take a new word only when both mappers are done and the result register is free
    // (or being emptied this cycle).
    assign s_ready   = !busy_x && !busy_y && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign hold_bumped = (hold_reg == '1) ? hold_reg : hold_reg + 1'b1;
    assign settle_dec  = (settle_reg != '0) ? settle_reg - 1'b1 : settle_reg;

    // Capture sequencer: one step per accepted word.
    always_comb begin
        phase_next        = phase_reg;
        settle_next       = settle_reg;
        timeout_left_next = timeout_left_reg;
        timeout_en_next   = timeout_en_reg;
        hold_next         = hold_reg;
        take_sample       = 1'b0;
        emit              = 1'b0;
        emit_timeout      = 1'b0;
        emit_hold         = hold_reg;

        if (accept) begin
            if (s_op == OP_ARM) begin
                // restart: drop whatever capture was in flight
                timeout_left_next = s_timeout_ms;
                timeout_en_next   = (s_timeout_ms != '0);
                phase_next        = PH_WAIT_PRESS;
                settle_next       = '0;
                hold_next         = '0;
            end else if (phase_reg != PH_IDLE) begin
                if (timeout_en_reg && phase_reg != PH_RELEASE_SETTLE) begin
                    timeout_left_next = timeout_left_reg - 1'b1;
                end
                if (timeout_en_reg && phase_reg != PH_RELEASE_SETTLE
                        && timeout_left_reg == TIMEOUT_BITS'(1)) begin
                    // timeout wins over any pen change on this tick
                    phase_next      = PH_IDLE;
                    timeout_en_next = 1'b0;
                    emit            = 1'b1;
                    emit_timeout    = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_WAIT_PRESS: begin
                            if (s_pen_down) begin
                                hold_next   = '0;
                                settle_next = press_settle_reg;
                                if (press_settle_reg == '0) begin
                                    take_sample = 1'b1;
                                    phase_next  = PH_WAIT_RELEASE;
                                end else begin
                                    phase_next  = PH_PRESS_SETTLE;
                                end
                            end
                        end
                        PH_PRESS_SETTLE: begin
                            hold_next   = hold_bumped;
                            settle_next = settle_dec;
                            if (settle_dec == '0) begin
                                take_sample = 1'b1;
                                phase_next  = PH_WAIT_RELEASE;
                            end
                        end
                        PH_WAIT_RELEASE: begin
                            hold_next = hold_bumped;
                            if (!s_pen_down) begin
                                settle_next = release_settle_reg;
                                if (release_settle_reg != '0) begin
                                    phase_next = PH_RELEASE_SETTLE;
                                end else begin
                                    phase_next      = PH_IDLE;
                                    timeout_en_next = 1'b0;
                                    emit            = 1'b1;
                                    emit_hold       = hold_bumped;
                                end
                            end
                        end
                        PH_RELEASE_SETTLE: begin
                            settle_next = settle_dec;
                            if (settle_dec == '0) begin
                                phase_next      = PH_IDLE;
                                timeout_en_next = 1'b0;
                                emit            = 1'b1;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // Result register: load on emit, drop once taken.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_pos_x_next  = m_pos_x_reg;
        m_pos_y_next  = m_pos_y_reg;
        m_hold_next   = m_hold_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            if (emit_timeout) begin
                m_status_next = STATUS_TIMEOUT;
                m_pos_x_next  = '0;
                m_pos_y_next  = '0;
                m_hold_next   = '0;
            end else begin
                m_status_next = STATUS_CAPTURED;
                m_pos_x_next  = POS_X_BITS'(held_x);
                m_pos_y_next  = POS_Y_BITS'(held_y);
                m_hold_next   = emit_hold;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Axis mapper requests: sample this tick's readings against the current window.
    always_comb begin
        map_req_x.start   = take_sample;
        map_req_x.sample  = s_sample_x;
        map_req_x.raw_min = x_raw_min_reg;
        map_req_x.raw_max = x_raw_max_reg;
        map_req_y.start   = take_sample;
        map_req_y.sample  = s_sample_y;
        map_req_y.raw_min = y_raw_min_reg;
        map_req_y.raw_max = y_raw_max_reg;
    end

    tpc_axis_map #(
        .SIZE   (SCREEN_WIDTH),
        .INVERT (1'b0)
    ) u_map_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req_x),
        .busy    (busy_x),
        .pos     (held_x)
    );

    // Y runs bottom-up on the panel, top-down on the screen
    tpc_axis_map #(
        .SIZE   (SCREEN_HEIGHT),
        .INVERT (1'b1)
    ) u_map_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req_y),
        .busy    (busy_y),
        .pos     (held_y)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_raw_min_reg      <= RST_RAW_MIN;
            x_raw_max_reg      <= RST_RAW_MAX;
            y_raw_min_reg      <= RST_RAW_MIN;
            y_raw_max_reg      <= RST_RAW_MAX;
            press_settle_reg   <= RST_SETTLE_MS;
            release_settle_reg <= RST_SETTLE_MS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_X_RAW_MIN:         x_raw_min_reg      <= cfg_data;
                REG_X_RAW_MAX:         x_raw_max_reg      <= cfg_data;
                REG_Y_RAW_MIN:         y_raw_min_reg      <= cfg_data;
                REG_Y_RAW_MAX:         y_raw_max_reg      <= cfg_data;
                REG_PRESS_SETTLE_MS:   press_settle_reg   <= cfg_data;
                REG_RELEASE_SETTLE_MS: release_settle_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            settle_reg       <= '0;
            timeout_left_reg <= '0;
            timeout_en_reg   <= 1'b0;
            hold_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            settle_reg       <= settle_next;
            timeout_left_reg <= timeout_left_next;
            timeout_en_reg   <= timeout_en_next;
            hold_reg         <= hold_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_pos_x_reg  <= m_pos_x_next;
        m_pos_y_reg  <= m_pos_y_next;
        m_hold_reg   <= m_hold_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_pos_x   = m_pos_x_reg;
    assign m_pos_y   = m_pos_y_reg;
    assign m_hold_ms = m_hold_reg;

endmodule

`default_nettype wire
